### design/data_processing_alu_flags_top_assert.svh
// ----------------------------------------------------------------------------
// data_processing_alu_flags_top_assert.svh
// Assertion macros used by the checker of the ALU block.
// ----------------------------------------------------------------------------
`ifndef DATA_PROCESSING_ALU_FLAGS_TOP_ASSERT_SVH
`define DATA_PROCESSING_ALU_FLAGS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DPAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DPAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/dpaf_pkg.sv
// ----------------------------------------------------------------------------
// dpaf_pkg
// Operation codes, flag positions and transaction types of the ALU block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpaf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 4;
  localparam int unsigned FlagW = 4;

  // Operation codes
  localparam logic [OpW-1:0] OP_AND = 4'd0;
  localparam logic [OpW-1:0] OP_EOR = 4'd1;
  localparam logic [OpW-1:0] OP_SUB = 4'd2;
  localparam logic [OpW-1:0] OP_RSB = 4'd3;
  localparam logic [OpW-1:0] OP_ADD = 4'd4;
  localparam logic [OpW-1:0] OP_ADC = 4'd5;
  localparam logic [OpW-1:0] OP_SBC = 4'd6;
  localparam logic [OpW-1:0] OP_RSC = 4'd7;
  localparam logic [OpW-1:0] OP_TST = 4'd8;
  localparam logic [OpW-1:0] OP_TEQ = 4'd9;
  localparam logic [OpW-1:0] OP_CMP = 4'd10;
  localparam logic [OpW-1:0] OP_CMN = 4'd11;
  localparam logic [OpW-1:0] OP_ORR = 4'd12;
  localparam logic [OpW-1:0] OP_MOV = 4'd13;
  localparam logic [OpW-1:0] OP_BIC = 4'd14;
  localparam logic [OpW-1:0] OP_MVN = 4'd15;

  // Mode codes
  localparam logic MODE_EXEC = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Flag bit positions
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  typedef struct packed {
    logic             mode;
    logic [OpW-1:0]   alu_op;
    logic [DataW-1:0] first_operand;
    logic [DataW-1:0] second_operand;
    logic             shift_carry;
    logic             set_flags;
    logic             dest_is_pc;
    logic [FlagW-1:0] flags_in;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             write_result;
    logic [FlagW-1:0] flags_out;
    logic             restore_status;
  } res_t;

endpackage

`default_nettype wire

### design/dpaf_alu.sv
// ----------------------------------------------------------------------------
// dpaf_alu
// Single-pass data-processing datapath: one adder, logic unit, flag update.
// ----------------------------------------------------------------------------
`default_nettype none

module dpaf_alu (
  input  dpaf_pkg::item_t                  item,
  input  logic [dpaf_pkg::FlagW-1:0]       flags_cur,
  output dpaf_pkg::res_t                   res
);

  logic [dpaf_pkg::DataW-1:0] add_x;
  logic [dpaf_pkg::DataW-1:0] add_y;
  logic                       add_cin;
  logic [dpaf_pkg::DataW:0]   sum;
  logic [dpaf_pkg::DataW-1:0] logic_r;
  logic                       is_logical;
  logic [dpaf_pkg::DataW-1:0] op_r;
  logic                       op_c;
  logic                       op_v;
  logic                       op_wr;
  logic                       carry_cur;
  logic [dpaf_pkg::FlagW-1:0] flags_calc;

  assign carry_cur = flags_cur[dpaf_pkg::FLAG_C];

  // Select adder operands or the logic result
  always_comb begin
    add_x      = item.first_operand;
    add_y      = ~item.second_operand;
    add_cin    = 1'b1;
    logic_r    = '0;
    is_logical = 1'b0;
    case (item.alu_op)
      dpaf_pkg::OP_AND, dpaf_pkg::OP_TST: begin
        logic_r    = item.first_operand & item.second_operand;
        is_logical = 1'b1;
      end
      dpaf_pkg::OP_EOR, dpaf_pkg::OP_TEQ: begin
        logic_r    = item.first_operand ^ item.second_operand;
        is_logical = 1'b1;
      end
      dpaf_pkg::OP_SUB, dpaf_pkg::OP_CMP: begin
        add_x   = item.first_operand;
        add_y   = ~item.second_operand;
        add_cin = 1'b1;
      end
      dpaf_pkg::OP_RSB: begin
        add_x   = item.second_operand;
        add_y   = ~item.first_operand;
        add_cin = 1'b1;
      end
      dpaf_pkg::OP_ADD, dpaf_pkg::OP_CMN: begin
        add_x   = item.first_operand;
        add_y   = item.second_operand;
        add_cin = 1'b0;
      end
      dpaf_pkg::OP_ADC: begin
        add_x   = item.first_operand;
        add_y   = item.second_operand;
        add_cin = carry_cur;
      end
      dpaf_pkg::OP_SBC: begin
        add_x   = item.first_operand;
        add_y   = ~item.second_operand;
        add_cin = carry_cur;
      end
      dpaf_pkg::OP_RSC: begin
        add_x   = item.second_operand;
        add_y   = ~item.first_operand;
        add_cin = carry_cur;
      end
      dpaf_pkg::OP_ORR: begin
        logic_r    = item.first_operand | item.second_operand;
        is_logical = 1'b1;
      end
      dpaf_pkg::OP_MOV: begin
        logic_r    = item.second_operand;
        is_logical = 1'b1;
      end
      dpaf_pkg::OP_BIC: begin
        logic_r    = item.first_operand & ~item.second_operand;
        is_logical = 1'b1;
      end
      default: begin
        logic_r    = ~item.second_operand;
        is_logical = 1'b1;
      end
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {{dpaf_pkg::DataW{1'b0}}, add_cin};

  assign op_r = is_logical ? logic_r : sum[dpaf_pkg::DataW-1:0];
  assign op_c = is_logical ? item.shift_carry : sum[dpaf_pkg::DataW];
  // Logical ops keep V
  assign op_v = is_logical ? flags_cur[dpaf_pkg::FLAG_V]
                           : ((add_x[dpaf_pkg::DataW-1] ^ op_r[dpaf_pkg::DataW-1]) &
                              (add_y[dpaf_pkg::DataW-1] ^ op_r[dpaf_pkg::DataW-1]));

  assign op_wr = !((item.alu_op == dpaf_pkg::OP_TST) || (item.alu_op == dpaf_pkg::OP_TEQ) ||
                   (item.alu_op == dpaf_pkg::OP_CMP) || (item.alu_op == dpaf_pkg::OP_CMN));

  assign flags_calc = {op_r[dpaf_pkg::DataW-1], (op_r == '0), op_c, op_v};

  always_comb begin
    res.result_value   = op_r;
    res.write_result   = op_wr;
    res.flags_out      = flags_cur;
    res.restore_status = 1'b0;
    if (item.mode == dpaf_pkg::MODE_LOAD) begin
      res.result_value = '0;
      res.write_result = 1'b0;
      res.flags_out    = item.flags_in;
    end else if (item.set_flags) begin
      if (item.dest_is_pc) begin
        res.restore_status = 1'b1;
      end else begin
        res.flags_out = flags_calc;
      end
    end
  end

endmodule

`default_nettype wire

### design/data_processing_alu_flags_top.sv
// ----------------------------------------------------------------------------
// data_processing_alu_flags_top
// Data-processing ALU, N Z C V condition flags, one transaction a cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_stall  | mode, op, operands, S, PC, flags
//  out_    | output    | out_valid/out_stall| result, write enable, flags, restore
//
//  An input transaction is held in the input register, then its result in the
//  result register on out_. One transaction a cycle is sustained while out_stall
//  is low; the condition flag register closes its loop through the single adder.
//  Reset clears both stage valids and the flags to zero.
//  A stalled result holds its register while one more transaction waits in
//  the input register; in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module data_processing_alu_flags_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [dpaf_pkg::OpW-1:0]      in_alu_op,
  input  logic [dpaf_pkg::DataW-1:0]    in_first_operand,
  input  logic [dpaf_pkg::DataW-1:0]    in_second_operand,
  input  logic                          in_shift_carry,
  input  logic                          in_set_flags,
  input  logic                          in_dest_is_pc,
  input  logic [dpaf_pkg::FlagW-1:0]    in_flags_in,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dpaf_pkg::DataW-1:0]    out_result_value,
  output logic                          out_write_result,
  output logic [dpaf_pkg::FlagW-1:0]    out_flags_out,
  output logic                          out_restore_status
);

  // Input register stage
  logic            s1_valid_r;
  logic            s1_valid_nxt;
  dpaf_pkg::item_t s1_item_r;

  // Result register stage
  logic            out_valid_r;
  logic            out_valid_nxt;
  dpaf_pkg::res_t  out_res_r;

  // Architectural condition flags
  logic [dpaf_pkg::FlagW-1:0] flags_r;
  logic [dpaf_pkg::FlagW-1:0] flags_nxt;

  dpaf_pkg::res_t  alu_res;
  logic            advance;
  logic            take_in;

  // Advance the input stage into the result register when that register is
  // empty or is being emptied this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;

  dpaf_alu u_alu (
    .item      (s1_item_r),
    .flags_cur (flags_r),
    .res       (alu_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take_in) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Commit the flags together with the transaction that produced them
  assign flags_nxt = advance ? alu_res.flags_out : flags_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_item_r.mode           <= in_mode;
      s1_item_r.alu_op         <= in_alu_op;
      s1_item_r.first_operand  <= in_first_operand;
      s1_item_r.second_operand <= in_second_operand;
      s1_item_r.shift_carry    <= in_shift_carry;
      s1_item_r.set_flags      <= in_set_flags;
      s1_item_r.dest_is_pc     <= in_dest_is_pc;
      s1_item_r.flags_in       <= in_flags_in;
    end
    if (advance) begin
      out_res_r <= alu_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_res_r.result_value;
  assign out_write_result   = out_res_r.write_result;
  assign out_flags_out      = out_res_r.flags_out;
  assign out_restore_status = out_res_r.restore_status;

endmodule

`default_nettype wire

### design/dpaf_checker.sv
// ----------------------------------------------------------------------------
// dpaf_checker
// Port-level assertions for the ALU block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "data_processing_alu_flags_top_assert.svh"

module dpaf_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [dpaf_pkg::DataW-1:0]    out_result_value,
  input  logic                          out_write_result,
  input  logic [dpaf_pkg::FlagW-1:0]    out_flags_out,
  input  logic                          out_restore_status
);

  // Flags shown by the last delivered transaction
  logic [dpaf_pkg::FlagW-1:0] last_flags_r;
  logic [dpaf_pkg::FlagW-1:0] last_flags_nxt;

  assign last_flags_nxt = (out_valid && !out_stall) ? out_flags_out : last_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_flags_r <= '0;
    end else begin
      last_flags_r <= last_flags_nxt;
    end
  end

  `DPAF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_value) && $stable(out_flags_out), "stalled result changed")

  `DPAF_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall, "input stalled with empty result stage")

  `DPAF_ASSERT_NOW(a_restore_keeps_flags, out_valid && out_restore_status, out_flags_out == last_flags_r, "flags changed on status restore")

  `DPAF_ASSERT_NOW(a_nz_match, out_valid && out_write_result && (out_flags_out != last_flags_r), (out_flags_out[dpaf_pkg::FLAG_N] == out_result_value[dpaf_pkg::DataW-1]) && (out_flags_out[dpaf_pkg::FLAG_Z] == (out_result_value == '0)), "N or Z does not match result")

endmodule

bind data_processing_alu_flags_top dpaf_checker u_dpaf_checker (.*);

`default_nettype wire

### tb/tb_data_processing_alu_flags_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_data_processing_alu_flags_top
// Self-checking bench for the data-processing ALU with N Z C V flags.
// A short walk through a row list covers every operation, the operand
// extremes, flag loads and the S-with-PC case. Randomised transactions
// follow, first with light sender gaps and a heavily stalling receiver, then
// the other way round, then at full rate. Every result is compared field by
// field against the row's typed answer, else a local copy of the ALU and flags.
// ----------------------------------------------------------------------------
module tb_data_processing_alu_flags_top;

  localparam int unsigned DataW       = dpaf_pkg::DataW;
  localparam int unsigned OpW         = dpaf_pkg::OpW;
  localparam int unsigned FlagW       = dpaf_pkg::FlagW;
  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned RandomItems = 1900;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;

  // One row of the directed walk; want is only meaningful when known is set
  typedef struct {
    dpaf_pkg::item_t txn;
    bit              known;
    dpaf_pkg::res_t  want;
  } alu_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic [OpW-1:0]     in_alu_op;
  logic [DataW-1:0]   in_first_operand;
  logic [DataW-1:0]   in_second_operand;
  logic               in_shift_carry;
  logic               in_set_flags;
  logic               in_dest_is_pc;
  logic [FlagW-1:0]   in_flags_in;
  logic               out_valid;
  logic               out_stall;
  logic [DataW-1:0]   out_result_value;
  logic               out_write_result;
  logic [FlagW-1:0]   out_flags_out;
  logic               out_restore_status;

  // Results still owed by the block, oldest first
  dpaf_pkg::res_t     alu_results_due[$];
  // Local copy of the condition flag register
  logic [FlagW-1:0]   nzcv_flags;
  alu_row_t           directed_rows[$];
  // Side information for the transaction currently on the input ports
  bit                 row_known;
  dpaf_pkg::res_t     row_want;
  int unsigned        mismatches;
  int unsigned        cycle_count;
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;

  data_processing_alu_flags_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_alu_op          (in_alu_op),
    .in_first_operand   (in_first_operand),
    .in_second_operand  (in_second_operand),
    .in_shift_carry     (in_shift_carry),
    .in_set_flags       (in_set_flags),
    .in_dest_is_pc      (in_dest_is_pc),
    .in_flags_in        (in_flags_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_value   (out_result_value),
    .out_write_result   (out_write_result),
    .out_flags_out      (out_flags_out),
    .out_restore_status (out_restore_status)
  );

  always #(HalfPeriod) clk = ~clk;

  // Execute one transaction against the local flag register and return the
  // result the block owes for it.
  function automatic dpaf_pkg::res_t alu_execute(input dpaf_pkg::item_t txn);
    logic [DataW-1:0] ax;
    logic [DataW-1:0] bx;
    logic [DataW-1:0] r;
    logic [DataW:0]   sum;
    logic             ci;
    logic             c;
    logic             v;
    logic             logical;
    dpaf_pkg::res_t   res;
    ax      = '0;
    bx      = '0;
    ci      = 1'b0;
    r       = '0;
    c       = nzcv_flags[dpaf_pkg::FLAG_C];
    v       = nzcv_flags[dpaf_pkg::FLAG_V];
    logical = 1'b0;
    res     = '0;
    if (txn.mode == dpaf_pkg::MODE_LOAD) begin
      nzcv_flags = txn.flags_in;
    end else begin
      // Subtracts are a + ~b + carry, so C reads as "no borrow"
      case (txn.alu_op)
        dpaf_pkg::OP_AND, dpaf_pkg::OP_TST: begin
          r = txn.first_operand & txn.second_operand; logical = 1'b1;
        end
        dpaf_pkg::OP_EOR, dpaf_pkg::OP_TEQ: begin
          r = txn.first_operand ^ txn.second_operand; logical = 1'b1;
        end
        dpaf_pkg::OP_SUB, dpaf_pkg::OP_CMP: begin
          ax = txn.first_operand;  bx = ~txn.second_operand; ci = 1'b1;
        end
        dpaf_pkg::OP_RSB: begin
          ax = txn.second_operand; bx = ~txn.first_operand;  ci = 1'b1;
        end
        dpaf_pkg::OP_ADD, dpaf_pkg::OP_CMN: begin
          ax = txn.first_operand;  bx = txn.second_operand;  ci = 1'b0;
        end
        dpaf_pkg::OP_ADC: begin
          ax = txn.first_operand;  bx = txn.second_operand;  ci = c;
        end
        dpaf_pkg::OP_SBC: begin
          ax = txn.first_operand;  bx = ~txn.second_operand; ci = c;
        end
        dpaf_pkg::OP_RSC: begin
          ax = txn.second_operand; bx = ~txn.first_operand;  ci = c;
        end
        dpaf_pkg::OP_ORR: begin
          r = txn.first_operand | txn.second_operand; logical = 1'b1;
        end
        dpaf_pkg::OP_MOV: begin
          r = txn.second_operand; logical = 1'b1;
        end
        dpaf_pkg::OP_BIC: begin
          r = txn.first_operand & ~txn.second_operand; logical = 1'b1;
        end
        default: begin
          r = ~txn.second_operand; logical = 1'b1;
        end
      endcase
      if (logical) begin
        // Logical operations take C from the shifter and keep V
        c = txn.shift_carry;
      end else begin
        sum = {1'b0, ax} + {1'b0, bx} + {{DataW{1'b0}}, ci};
        r   = sum[DataW-1:0];
        c   = sum[DataW];
        v   = (ax[DataW-1] ^ r[DataW-1]) & (bx[DataW-1] ^ r[DataW-1]);
      end
      res.write_result = !(txn.alu_op inside {dpaf_pkg::OP_TST, dpaf_pkg::OP_TEQ,
                                              dpaf_pkg::OP_CMP, dpaf_pkg::OP_CMN});
      if (txn.set_flags) begin
        if (txn.dest_is_pc) begin
          // Status restore request; flags stay as they are
          res.restore_status = 1'b1;
        end else begin
          nzcv_flags[dpaf_pkg::FLAG_N] = r[DataW-1];
          nzcv_flags[dpaf_pkg::FLAG_Z] = (r == '0);
          nzcv_flags[dpaf_pkg::FLAG_C] = c;
          nzcv_flags[dpaf_pkg::FLAG_V] = v;
        end
      end
    end
    res.result_value = r;
    res.flags_out    = nzcv_flags;
    return res;
  endfunction

  function automatic void add_row(input logic mode, input logic [OpW-1:0] op,
                                  input logic [DataW-1:0] a, input logic [DataW-1:0] b,
                                  input logic sc, input logic s, input logic pc,
                                  input logic [FlagW-1:0] fin, input bit known,
                                  input dpaf_pkg::res_t want);
    alu_row_t row;
    row.txn   = '{mode, op, a, b, sc, s, pc, fin};
    row.known = known;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Bias operands towards the values where carry and overflow turn over
  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic dpaf_pkg::item_t random_txn();
    dpaf_pkg::item_t txn;
    txn.mode           = ($urandom_range(9) == 0) ? dpaf_pkg::MODE_LOAD : dpaf_pkg::MODE_EXEC;
    txn.alu_op         = OpW'($urandom_range(15));
    txn.first_operand  = pick_operand();
    txn.second_operand = pick_operand();
    txn.shift_carry    = 1'($urandom_range(1));
    txn.set_flags      = ($urandom_range(3) != 0);
    txn.dest_is_pc     = ($urandom_range(3) == 0);
    txn.flags_in       = FlagW'($urandom_range(15));
    return txn;
  endfunction

  function automatic void check_field(input string name, input logic [DataW-1:0] want,
                                      input logic [DataW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Present one transaction from a falling edge, hold it until accepted,
  // and return at the next falling edge.
  task automatic send_txn(input dpaf_pkg::item_t txn, input bit known,
                          input dpaf_pkg::res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= txn.mode;
    in_alu_op         <= txn.alu_op;
    in_first_operand  <= txn.first_operand;
    in_second_operand <= txn.second_operand;
    in_shift_carry    <= txn.shift_carry;
    in_set_flags      <= txn.set_flags;
    in_dest_is_pc     <= txn.dest_is_pc;
    in_flags_in       <= txn.flags_in;
    row_known = known;
    row_want  = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check the outgoing transaction first, then log the incoming one, so a
  // result is never matched against a transaction accepted at the same edge.
  always @(posedge clk) begin
    dpaf_pkg::res_t  seen;
    dpaf_pkg::res_t  want;
    dpaf_pkg::res_t  calc;
    dpaf_pkg::item_t txn;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = '{out_result_value, out_write_result, out_flags_out, out_restore_status};
        if (alu_results_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, seen);
        end else begin
          want = alu_results_due.pop_front();
          check_field("result_value", want.result_value, seen.result_value);
          check_field("write_result", DataW'(want.write_result), DataW'(seen.write_result));
          check_field("flags_out", DataW'(want.flags_out), DataW'(seen.flags_out));
          check_field("restore_status", DataW'(want.restore_status),
                      DataW'(seen.restore_status));
        end
      end
      if (in_valid && !in_stall) begin
        txn  = '{in_mode, in_alu_op, in_first_operand, in_second_operand,
                 in_shift_carry, in_set_flags, in_dest_is_pc, in_flags_in};
        // Always advance the local flags, even when the answer is typed in
        calc = alu_execute(txn);
        alu_results_due.push_back(row_known ? row_want : calc);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_mode           = dpaf_pkg::MODE_EXEC;
    in_alu_op         = dpaf_pkg::OP_AND;
    in_first_operand  = '0;
    in_second_operand = '0;
    in_shift_carry    = 1'b0;
    in_set_flags      = 1'b0;
    in_dest_is_pc     = 1'b0;
    in_flags_in       = '0;
    out_stall         = 1'b0;
    nzcv_flags        = '0;
    row_known         = 1'b0;
    row_want          = '0;
    mismatches        = 0;
    cycle_count       = 0;
    send_idle_pct     = 17;
    recv_stall_pct    = 67;

    // Rows with a typed answer track the flags by hand from reset (all clear)
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_MOV, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 4'h0,
            1'b1, '{32'h0, 1'b1, 4'b0000, 1'b0});
    // Flag load ignores the operation fields
    add_row(dpaf_pkg::MODE_LOAD, dpaf_pkg::OP_SUB, '1, '1, 1'b1, 1'b1, 1'b1, 4'hF,
            1'b1, '{32'h0, 1'b0, 4'b1111, 1'b0});
    add_row(dpaf_pkg::MODE_LOAD, dpaf_pkg::OP_MVN, '0, '0, 1'b0, 1'b0, 1'b0, 4'h0,
            1'b1, '{32'h0, 1'b0, 4'b0000, 1'b0});
    // Add wraps to zero with carry out
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_ADD, '1, 32'h1, 1'b0, 1'b1, 1'b0, 4'h0,
            1'b1, '{32'h0, 1'b1, 4'b0110, 1'b0});
    // Add with carry overflows into the sign bit
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_ADC, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b1, 1'b0,
            4'h0, 1'b1, '{32'h8000_0000, 1'b1, 4'b1001, 1'b0});
    // Subtract with borrow
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_SUB, 32'h0, 32'h1, 1'b1, 1'b1, 1'b0, 4'h0,
            1'b1, '{32'hFFFF_FFFF, 1'b1, 4'b1000, 1'b0});
    // Compare: signed overflow, no borrow, no write
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_CMP, 32'h8000_0000, 32'h1, 1'b0, 1'b1, 1'b0,
            4'h0, 1'b1, '{32'h7FFF_FFFF, 1'b0, 4'b0011, 1'b0});
    // Test takes C from the shifter and keeps V
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_TST, '1, '0, 1'b1, 1'b1, 1'b0, 4'h0,
            1'b1, '{32'h0, 1'b0, 4'b0111, 1'b0});
    // S with PC destination: restore request, flags untouched
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_ADD, 32'h1, 32'h1, 1'b0, 1'b1, 1'b1, 4'h0,
            1'b1, '{32'h2, 1'b1, 4'b0111, 1'b1});
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_CMN, 32'h7FFF_FFFF, 32'h1, 1'b0, 1'b1, 1'b1,
            4'h0, 1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_EOR, '1, 32'hAAAA_AAAA, 1'b0, 1'b1, 1'b0,
            4'h0, 1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_RSB, 32'h5, 32'h3, 1'b0, 1'b1, 1'b0, 4'h0,
            1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_SBC, '0, '0, 1'b0, 1'b1, 1'b0, 4'h0,
            1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_RSC, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1,
            1'b0, 4'h0, 1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_TEQ, 32'h1234_5678, 32'h1234_5678, 1'b1, 1'b1,
            1'b0, 4'h0, 1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_ORR, '0, '0, 1'b0, 1'b1, 1'b0, 4'h0,
            1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_BIC, '1, 32'h0F0F_0F0F, 1'b1, 1'b1, 1'b0,
            4'h0, 1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_MVN, '0, '0, 1'b0, 1'b0, 1'b0, 4'h0,
            1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_AND, 32'h8000_0000, '1, 1'b1, 1'b1, 1'b0,
            4'h0, 1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_SUB, 32'h8000_0000, 32'h1, 1'b0, 1'b1, 1'b0,
            4'h0, 1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_ADC, '1, '1, 1'b0, 1'b1, 1'b0, 4'h0,
            1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_SBC, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0,
            1'b1, 4'h0, 1'b0, '0);
    add_row(dpaf_pkg::MODE_EXEC, dpaf_pkg::OP_MOV, '1, '1, 1'b1, 1'b1, 1'b1, 4'h0,
            1'b0, '0);
    add_row(dpaf_pkg::MODE_LOAD, dpaf_pkg::OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0,
            1'b1, 4'hA, 1'b0, '0);

    // Hold reset, then release it away from the active edge
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_txn(directed_rows[i].txn, directed_rows[i].known, directed_rows[i].want);
    end

    // Three idling regimes: slow receiver, slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 17; recv_stall_pct = 67; end
        1:       begin send_idle_pct = 67; recv_stall_pct = 17; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (int n = 0; n < RandomItems / 3; n++) begin
        send_txn(random_txn(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    while (alu_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && alu_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/dpaf_pkg.sv
design/dpaf_alu.sv
design/data_processing_alu_flags_top.sv
design/dpaf_checker.sv
tb/tb_data_processing_alu_flags_top.sv
